// ===== rtl/core/tape_recording_header_scanner_top_macros.svh =====
// Assertion macros for the tape header scanner.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef TAPE_RECORDING_HEADER_SCANNER_TOP_MACROS_SVH
`define TAPE_RECORDING_HEADER_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TRHS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define TRHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/trhs_pkg.sv =====
// Package for the tape header scanner: item types, byte codes and limits.
// No dependencies; used by tape_recording_header_scanner_top.
`timescale 1ns / 1ps
`default_nettype none

package trhs_pkg;

	// Name and record limits
	localparam int NAME_MAX       = 99;
	localparam int MAX_RECORDINGS = 128;

	localparam int NAME_IDX_W = 7;
	localparam int POS_W      = 32;
	localparam int BYTE_W     = 8;

	// Tape byte codes
	localparam logic [BYTE_W-1:0] FILLER_BYTE = 8'hFF;
	localparam logic [BYTE_W-1:0] MARK_BYTE   = 8'h2F;
	localparam logic [BYTE_W-1:0] END_BYTE    = 8'h0D;
	localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;
	localparam logic [BYTE_W-1:0] QUOTE_BYTE  = 8'h27;

	localparam logic [BYTE_W-1:0] CLAMP_RESET = 8'd40;
	localparam logic [BYTE_W-1:0] COUNT_MAX   = 8'hFF;

	// Result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] tape_byte;
		logic              restart;
	} in_t;

	typedef struct packed {
		logic                  kind;
		logic [BYTE_W-1:0]     name_byte;
		logic [NAME_IDX_W-1:0] name_index;
		logic [POS_W-1:0]      start_position;
		logic [BYTE_W-1:0]     record_index;
		logic                  kept;
	} out_t;

endpackage

`default_nettype wire

// ===== rtl/core/tape_recording_header_scanner_top.sv =====
// Tape header scanner: scan state, record start arithmetic, output register.
// Depends on trhs_pkg and tape_recording_header_scanner_top_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one tape byte per item;
//   set restart on the first byte of a new scan to clear position and counts.
//   Output channel (out_valid / out_stall / out_data) gives at most one item
//   per input byte: a name character (kind 0) or a record completion (kind 1)
//   with the start offset, name length, record index and kept flag.
//   cfg_we / cfg_data write the filler clamp (reset value 40); write only
//   while no item is in flight.
//   Each result is registered and appears in the cycle after its byte is accepted.
//   Throughput: one byte per cycle while in_stall is low; the only loop is the scan
//   state update, one compare-and-count step per byte ahead of a single output register.
//   Stall: while the output register holds an item and out_stall is high,
//   in_stall is raised and the block holds its state and result.
//   Reset: clears all scan state, empties the output register and sets the
//   clamp to 40.
`timescale 1ns / 1ps
`default_nettype none
`include "tape_recording_header_scanner_top_macros.svh"

module tape_recording_header_scanner_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire trhs_pkg::in_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output trhs_pkg::out_t     out_data,
	input  wire logic          cfg_we,
	input  wire logic [7:0]    cfg_data
);

	localparam int NW = trhs_pkg::NAME_IDX_W;
	localparam int PW = trhs_pkg::POS_W;
	localparam int BW = trhs_pkg::BYTE_W;
	localparam logic [NW-1:0] NAME_MAX_C = NW'(trhs_pkg::NAME_MAX);
	localparam logic [BW-1:0] MAX_REC_C  = BW'(trhs_pkg::MAX_RECORDINGS);

	// Scan state; the filler count saturates at 255, enough against an 8-bit clamp
	logic [BW-1:0] clamp_q;
	logic [PW-1:0] pos_q, marker_q;
	logic [BW-1:0] filler_q, count_q;
	logic          in_name_q;
	logic [NW-1:0] len_q;

	logic          out_valid_q;
	trhs_pkg::out_t out_data_q;

	// Effective state after restart, next state and result
	logic [PW-1:0] pos_e, marker_e, pos_n, marker_n;
	logic [BW-1:0] filler_e, count_e, filler_n, count_n;
	logic          in_name_e, in_name_n;
	logic [NW-1:0] len_e, len_n;
	logic          accept, res_valid, done;
	logic [NW-1:0] done_len;
	logic [BW-1:0] back;
	logic [PW-1:0] rec_start;
	trhs_pkg::out_t res;

	assign accept = in_valid && !in_stall;
	assign in_stall = out_valid_q && out_stall;

	// Clear the scan ahead of the byte when restart is set
	always_comb begin
		if (in_data.restart) begin
			pos_e     = '0;
			marker_e  = '0;
			filler_e  = '0;
			count_e   = '0;
			in_name_e = 1'b0;
			len_e     = '0;
		end else begin
			pos_e     = pos_q;
			marker_e  = marker_q;
			filler_e  = filler_q;
			count_e   = count_q;
			in_name_e = in_name_q;
			len_e     = len_q;
		end
	end

	// Record start: marker - 1 - min(filler, clamp), floored at zero
	always_comb begin
		back = (filler_e > clamp_q) ? clamp_q : filler_e;
		if (marker_e > PW'(back))
			rec_start = marker_e - PW'(back) - PW'(1);
		else
			rec_start = '0;
	end

	// Scan one byte
	always_comb begin
		pos_n     = pos_e + PW'(1);
		marker_n  = marker_e;
		filler_n  = filler_e;
		count_n   = count_e;
		in_name_n = in_name_e;
		len_n     = len_e;
		res_valid = 1'b0;
		done      = 1'b0;
		done_len  = len_e;

		res.kind           = trhs_pkg::KIND_CHAR;
		res.name_byte      = in_data.tape_byte;
		res.name_index     = len_e;
		res.start_position = '0;
		res.record_index   = count_e;
		res.kept           = (count_e < MAX_REC_C);

		if (in_name_e) begin
			res_valid = 1'b1;
			if (len_e >= NAME_MAX_C) begin
				done     = 1'b1;
				done_len = NAME_MAX_C;
			end else if (in_data.tape_byte == trhs_pkg::END_BYTE) begin
				done = 1'b1;
			end else begin
				len_n = len_e + NW'(1);
			end
		end else begin
			if (in_data.tape_byte == trhs_pkg::FILLER_BYTE) begin
				if (filler_e != trhs_pkg::COUNT_MAX)
					filler_n = filler_e + BW'(1);
			end else if (in_data.tape_byte == trhs_pkg::MARK_BYTE) begin
				marker_n  = pos_e;
				in_name_n = 1'b1;
				len_n     = '0;
			end else if (in_data.tape_byte != trhs_pkg::ZERO_BYTE &&
				     in_data.tape_byte != trhs_pkg::QUOTE_BYTE) begin
				filler_n = '0;
			end
		end

		// Close the record
		if (done) begin
			res.kind           = trhs_pkg::KIND_DONE;
			res.name_byte      = '0;
			res.name_index     = done_len;
			res.start_position = rec_start;
			if (count_e != trhs_pkg::COUNT_MAX)
				count_n = count_e + BW'(1);
			filler_n  = '0;
			in_name_n = 1'b0;
			len_n     = '0;
		end
	end

	// Hold the filler clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q <= trhs_pkg::CLAMP_RESET;
		end else if (cfg_we) begin
			clamp_q <= cfg_data;
		end
	end

	// Advance scan state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			marker_q  <= '0;
			filler_q  <= '0;
			count_q   <= '0;
			in_name_q <= 1'b0;
			len_q     <= '0;
		end else if (accept) begin
			pos_q     <= pos_n;
			marker_q  <= marker_n;
			filler_q  <= filler_n;
			count_q   <= count_n;
			in_name_q <= in_name_n;
			len_q     <= len_n;
		end
	end

	// Load the output register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Checks on scan state and results
	`TRHS_ASSERT_NOW(a_len_idle, !in_name_q, len_q == '0, "name length set outside a name")
	`TRHS_ASSERT_NOW(a_len_max, 1'b1, len_q <= NAME_MAX_C, "name length above limit")
	`TRHS_ASSERT_NEXT(a_done_close, accept && done, !in_name_q && out_valid_q && out_data_q.kind, "record completion did not close the name")
	`TRHS_ASSERT_NOW(a_done_byte, out_valid_q && out_data_q.kind, out_data_q.name_byte == '0, "completion item carries a name byte")

endmodule

`default_nettype wire

// ===== bench/tape_recording_header_scanner_top_test.sv =====
// Self-checking bench for tape_recording_header_scanner_top: directed and random tape streams.
// Needs trhs_pkg and the scanner RTL; an in-bench scoreboard predicts every result item.
`timescale 1ns / 1ps

module tape_recording_header_scanner_top_test;
	import trhs_pkg::*;

	localparam int RESET_CYCLES   = 12;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 4;

	// Scoreboard: tracks scanner state and keeps the result items still to come
	class record_scoreboard;
		logic [7:0]  clamp;
		logic [31:0] byte_pos;
		logic [31:0] filler_cnt;
		logic [31:0] marker_pos;
		logic        in_name;
		logic [6:0]  name_cnt;
		logic [7:0]  rec_cnt;
		out_t        expected_items[$];
		int          fail_count;

		function new();
			clamp = CLAMP_RESET;
			fail_count = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			byte_pos = '0;
			filler_cnt = '0;
			marker_pos = '0;
			in_name = 1'b0;
			name_cnt = '0;
			rec_cnt = '0;
		endfunction

		function void set_clamp(logic [7:0] value);
			clamp = value;
		endfunction

		function int pending();
			return expected_items.size();
		endfunction

		function string fmt(out_t r);
			return $sformatf("kind=%0d byte=%02h idx=%0d start=%0d rec=%0d kept=%0d",
				r.kind, r.name_byte, r.name_index, r.start_position, r.record_index, r.kept);
		endfunction

		function void report(string msg);
			fail_count++;
			if (fail_count <= 10)
				$display("[%0t] mismatch: %s", $time, msg);
		endfunction

		// Close the current name: start offset counts back over clamped filler
		function out_t close_record(logic [6:0] len);
			out_t        res;
			logic [31:0] back;
			back = (filler_cnt > {24'd0, clamp}) ? {24'd0, clamp} : filler_cnt;
			res.kind = KIND_DONE;
			res.name_byte = '0;
			res.name_index = len;
			res.start_position = (marker_pos >= back + 32'd1) ? marker_pos - 32'd1 - back : '0;
			res.record_index = rec_cnt;
			res.kept = (rec_cnt < MAX_RECORDINGS);
			if (rec_cnt != 8'hFF)
				rec_cnt++;
			filler_cnt = '0;
			in_name = 1'b0;
			name_cnt = '0;
			return res;
		endfunction

		// Advance the scan by one accepted tape byte
		function void scan_byte(in_t item);
			out_t res;
			if (item.restart)
				clear_scan();
			if (in_name) begin
				if (name_cnt >= NAME_MAX) begin
					expected_items.push_back(close_record(7'(NAME_MAX)));
				end else if (item.tape_byte == END_BYTE) begin
					expected_items.push_back(close_record(name_cnt));
				end else begin
					res.kind = KIND_CHAR;
					res.name_byte = item.tape_byte;
					res.name_index = name_cnt;
					res.start_position = '0;
					res.record_index = rec_cnt;
					res.kept = (rec_cnt < MAX_RECORDINGS);
					expected_items.push_back(res);
					name_cnt++;
				end
			end else begin
				if (item.tape_byte == FILLER_BYTE) begin
					if (filler_cnt != 32'hFFFF_FFFF)
						filler_cnt++;
				end else if (item.tape_byte == MARK_BYTE) begin
					marker_pos = byte_pos;
					in_name = 1'b1;
					name_cnt = '0;
				end else if (item.tape_byte != ZERO_BYTE && item.tape_byte != QUOTE_BYTE) begin
					filler_cnt = '0;
				end
			end
			byte_pos++;
		endfunction

		// Compare one result item with the oldest expectation
		function void check_result(out_t got);
			out_t want;
			logic bad;
			if (expected_items.size() == 0) begin
				report({"unexpected item: ", fmt(got)});
			end else begin
				want = expected_items.pop_front();
				bad = (got.kind !== want.kind) || (got.name_byte !== want.name_byte) ||
					(got.name_index !== want.name_index) ||
					(got.start_position !== want.start_position) ||
					(got.record_index !== want.record_index) || (got.kept !== want.kept);
				if (bad)
					report({"expected ", fmt(want), " got ", fmt(got)});
			end
		endfunction

		function void flush_leftovers();
			while (expected_items.size() > 0)
				report({"missing item: ", fmt(expected_items.pop_front())});
		endfunction
	endclass

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_t        in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_t       out_data;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_data = '0;

	record_scoreboard sb;
	in_t              stim_q[$];
	int               burst_left = 0;
	bit               hold_req = 1'b0;

	tape_recording_header_scanner_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Observe both channels at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(out_data);
			if (in_valid && !in_stall)
				sb.scan_byte(in_data);
		end
	end

	// Receiver: random stall stretches, plus one long hold on request
	initial begin : receiver
		int len;
		int pct;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end else begin
				len = $urandom_range(1, 40);
				case ($urandom_range(0, 3))
					0: pct = 0;
					1: pct = 25;
					2: pct = 60;
					default: pct = 90;
				endcase
				repeat (len) begin
					out_stall <= ($urandom_range(0, 99) < pct);
					@(posedge clk);
				end
			end
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	function automatic void push_byte(logic [7:0] b, logic rs);
		in_t item;
		item.tape_byte = b;
		item.restart = rs;
		stim_q.push_back(item);
	endfunction

	// Random records: filler run, marker, name, terminator; some noise in between
	function automatic void gen_records(int count, bit long_fill);
		int         base;
		int         fill_len;
		int         len;
		int         sel;
		logic       rs;
		logic [7:0] b;
		base = stim_q.size();
		while (stim_q.size() - base < count) begin
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 8))
					push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) == 0);
			end else begin
				rs = ($urandom_range(0, 99) < 6);
				sel = $urandom_range(0, 9);
				if (sel < 7)
					fill_len = $urandom_range(0, 50);
				else if (sel < 9 || !long_fill)
					fill_len = $urandom_range(0, 8);
				else
					fill_len = $urandom_range(200, 320);
				for (int i = 0; i < fill_len; i++) begin
					case ($urandom_range(0, 19))
						0: b = ZERO_BYTE;
						1: b = QUOTE_BYTE;
						2: b = 8'($urandom_range(0, 255));
						default: b = FILLER_BYTE;
					endcase
					push_byte(b, rs && i == 0);
				end
				push_byte(MARK_BYTE, rs && fill_len == 0);
				sel = $urandom_range(0, 9);
				if (sel < 8)
					len = $urandom_range(0, 12);
				else if (sel == 8)
					len = $urandom_range(90, NAME_MAX - 1);
				else
					len = NAME_MAX;
				for (int i = 0; i < len; i++) begin
					b = ($urandom_range(0, 9) == 0) ? ZERO_BYTE : 8'($urandom_range(0, 255));
					if (b == END_BYTE)
						b = b ^ 8'h01;
					push_byte(b, $urandom_range(0, 299) == 0);
				end
				// truncated names drop one byte of any value
				if (len == NAME_MAX)
					push_byte(($urandom_range(0, 3) == 0) ? END_BYTE : 8'($urandom_range(0, 255)),
						1'b0);
				else
					push_byte(END_BYTE, 1'b0);
			end
		end
	endfunction

	// Many short records in one scan, past the stored maximum and the count limit
	function automatic void gen_flood(int records);
		logic [7:0] b;
		push_byte(8'h55, 1'b1);
		repeat (records) begin
			push_byte(MARK_BYTE, 1'b0);
			if ($urandom_range(0, 4) == 0) begin
				b = 8'($urandom_range(0, 255));
				push_byte((b == END_BYTE) ? ZERO_BYTE : b, 1'b0);
			end
			push_byte(END_BYTE, 1'b0);
		end
	endfunction

	// Feed the stimulus queue in bursts with random gaps
	task automatic send_items();
		in_t item;
		int  gap;
		while (stim_q.size() > 0) begin
			item = stim_q.pop_front();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
				repeat (gap) begin
					in_valid <= 1'b0;
					@(posedge clk);
				end
			end
			in_valid <= 1'b1;
			in_data <= item;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			burst_left--;
		end
		in_valid <= 1'b0;
	endtask

	// Step one edge first so the last accepted item is already predicted
	task automatic drain();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the clamp only once the block has gone quiet
	task automatic write_clamp(logic [7:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_clamp(value);
	endtask

	initial begin : main
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: marker at offset zero, empty name, filler with neutral bytes,
		// embedded zero, restart inside a name, both extremes of the byte
		push_byte(MARK_BYTE, 1'b1);
		push_byte(END_BYTE, 1'b0);
		push_byte(FILLER_BYTE, 1'b0);
		push_byte(FILLER_BYTE, 1'b0);
		push_byte(ZERO_BYTE, 1'b0);
		push_byte(QUOTE_BYTE, 1'b0);
		push_byte(FILLER_BYTE, 1'b0);
		push_byte(MARK_BYTE, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(ZERO_BYTE, 1'b0);
		push_byte(FILLER_BYTE, 1'b0);
		push_byte(MARK_BYTE, 1'b0);
		push_byte(END_BYTE, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(FILLER_BYTE, 1'b0);
		push_byte(MARK_BYTE, 1'b0);
		push_byte(END_BYTE, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(MARK_BYTE, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h42, 1'b1);
		push_byte(FILLER_BYTE, 1'b1);
		push_byte(MARK_BYTE, 1'b0);
		push_byte(END_BYTE, 1'b0);
		send_items();

		write_clamp(8'd0);
		gen_records(280, 1'b0);
		send_items();

		// Long filler runs past the widest clamp, with the receiver held off
		write_clamp(8'd255);
		gen_records(300, 1'b1);
		hold_req = 1'b1;
		send_items();

		write_clamp(8'd1);
		gen_flood(265);
		send_items();

		write_clamp(8'($urandom_range(0, 255)));
		gen_records(280, 1'b1);
		send_items();

		drain();
		sb.flush_leftovers();
		if (sb.fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
